[design/mtep_pkg.sv]
// ----------------------------------------------------------------------------
// mtep_pkg: shared types and constants of the MIDI track event parser
// Parse phases, result kinds, error codes and the result record.
// ----------------------------------------------------------------------------
package mtep_pkg;

	// longest variable-length number, in bytes
	localparam int unsigned MAX_NUMBER_BYTES = 16;
	localparam int unsigned CNT_W            = 5;

	localparam logic [7:0] BYTE_SYSEX     = 8'hf0;
	localparam logic [7:0] BYTE_SYSEX_END = 8'hf7;
	localparam logic [7:0] BYTE_SKIP_LO   = 8'hf1;
	localparam logic [7:0] BYTE_SKIP_HI   = 8'hfe;
	localparam logic [7:0] BYTE_META      = 8'hff;
	localparam logic [7:0] META_END_TRACK = 8'h2f;
	localparam logic [13:0] BEND_CENTER   = 14'd8192;

	localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
	localparam logic [3:0] HI_NOTE_ON   = 4'h9;
	localparam logic [3:0] HI_POLY_AT   = 4'ha;
	localparam logic [3:0] HI_PROGRAM   = 4'hc;
	localparam logic [3:0] HI_PRESSURE  = 4'hd;
	localparam logic [3:0] HI_BEND      = 4'he;
	localparam logic [3:0] HI_SYSTEM    = 4'hf;

	typedef enum logic [3:0] {
		PH_DELTA     = 4'd0,
		PH_STATUS    = 4'd1,
		PH_DATA_A    = 4'd2,
		PH_DATA_B    = 4'd3,
		PH_SYS_LEN   = 4'd4,
		PH_META_TYPE = 4'd5,
		PH_META_LEN  = 4'd6,
		PH_PAYLOAD   = 4'd7,
		PH_ERROR     = 4'd8
	} phase_t;

	typedef enum logic [3:0] {
		KIND_NOTE_OFF  = 4'd0,
		KIND_NOTE_ON   = 4'd1,
		KIND_CTRL      = 4'd2,
		KIND_PROGRAM   = 4'd3,
		KIND_PRESSURE  = 4'd4,
		KIND_BEND      = 4'd5,
		KIND_SYSEX_HDR = 4'd6,
		KIND_META_HDR  = 4'd7,
		KIND_PAYLOAD   = 4'd8,
		KIND_END       = 4'd9,
		KIND_ERROR     = 4'd10
	} kind_t;

	typedef enum logic [1:0] {
		ERR_TOO_LONG  = 2'd0,
		ERR_NO_STATUS = 2'd1,
		ERR_BAD_STAT  = 2'd2,
		ERR_STRAY_B7  = 2'd3
	} err_t;

	typedef struct packed {
		kind_t              kind;
		err_t               error_code;
		logic [3:0]         channel;
		logic [31:0]        tick;
		logic [7:0]         number;
		logic signed [13:0] amount;
		logic [31:0]        payload_length;
		logic [7:0]         data_byte;
		logic               is_terminator;
		logic               last;
	} result_t;

endpackage

[design/midi_track_event_parser_unit.sv]
// ----------------------------------------------------------------------------
// midi_track_event_parser_unit: MIDI track byte stream to event decoder
// Decodes delta times, running status, channel messages, sysex and meta.
// ----------------------------------------------------------------------------
// Usage
//   Input stream: one track byte per transaction in s_axis_tdata; s_axis_tuser
//   set marks the first byte of a new track and clears tick, statuses, errors.
//   Output stream: at most one event per input byte; kind and terminator flag
//   in m_axis_tuser, event fields in m_axis_tdata, m_axis_tlast marks a header
//   with empty payload or the final payload byte.
//   Output: m_axis is driven from a register. Throughput: one byte per cycle while
//   s_axis_tready is high; the whole parse step is one pass of logic from
//   the parser state and the byte into the result register.
//   Stalls: a result register plus a one-entry skid buffer; while the receiver
//   stalls the block keeps taking bytes until one more event waits in the skid
//   entry, then drops s_axis_tready until the skid entry drains.
//   Reset: parser waits for a delta time, tick is zero, no running status,
//   both output entries empty.
//   After an error or end of track, bytes are consumed silently until a
//   transaction with s_axis_tuser set.
// ----------------------------------------------------------------------------
module midi_track_event_parser_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] byte_in
	input  logic         s_axis_tuser,   // [0] start_track
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [1:0] error_code, [5:2] channel, [37:6] tick, [45:38] number,
	// [59:46] amount, [91:60] payload_length, [99:92] data_byte, [103:100] zero
	output logic [103:0] m_axis_tdata,
	output logic [4:0]   m_axis_tuser,   // [3:0] kind, [4] is_terminator
	output logic         m_axis_tlast
);
	import mtep_pkg::*;

	// parser state
	phase_t            phase_q;
	logic              rs_none_q, ss_none_q;
	logic [7:0]        rs_q, ss_q;
	logic [31:0]       tick_q, acc_q, rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [7:0]        first_q, meta_q;
	logic              in_sysex_q, halted_q;

	// next state
	phase_t            phase_n;
	logic              rs_none_n, ss_none_n;
	logic [7:0]        rs_n, ss_n;
	logic [31:0]       tick_n, acc_n, rem_n;
	logic [CNT_W-1:0]  cnt_n;
	logic [7:0]        first_n, meta_n;
	logic              in_sysex_n, halted_n;

	// output register and skid entry
	logic              out_valid_q, skid_valid_q;
	result_t           out_q, skid_q;

	logic              accept, out_free;
	logic              res_valid;
	result_t           res;

	// state as seen by this byte (start of track clears it first)
	phase_t            ph;
	logic              rs_none, ss_none, halted_w;
	logic [7:0]        rs, ss, b, a;
	logic [31:0]       tick_w, acc_w, acc_add, rem_w, rem_dec;
	logic [CNT_W-1:0]  cnt_w, cnt_inc;
	logic [CNT_W:0]    cnt_ext;

	assign s_axis_tready = !skid_valid_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign b             = s_axis_tdata;

	// one parse step
	always_comb begin
		ph       = s_axis_tuser ? PH_DELTA : phase_q;
		rs_none  = s_axis_tuser ? 1'b1 : rs_none_q;
		ss_none  = s_axis_tuser ? 1'b1 : ss_none_q;
		rs       = rs_q;
		ss       = ss_q;
		tick_w   = s_axis_tuser ? '0 : tick_q;
		acc_w    = s_axis_tuser ? '0 : acc_q;
		cnt_w    = s_axis_tuser ? '0 : cnt_q;
		rem_w    = s_axis_tuser ? '0 : rem_q;
		halted_w = s_axis_tuser ? 1'b0 : halted_q;
		a        = s_axis_tuser ? '0 : first_q;

		phase_n    = ph;
		rs_none_n  = rs_none;
		ss_none_n  = ss_none;
		rs_n       = rs;
		ss_n       = ss;
		tick_n     = tick_w;
		acc_n      = acc_w;
		cnt_n      = cnt_w;
		rem_n      = rem_w;
		first_n    = a;
		meta_n     = s_axis_tuser ? '0 : meta_q;
		in_sysex_n = s_axis_tuser ? 1'b0 : in_sysex_q;
		halted_n   = halted_w;

		res_valid  = 1'b0;
		res        = '0;
		res.tick   = tick_w;

		// variable-length number step
		acc_add = acc_w + {25'd0, b[6:0]};
		cnt_inc = cnt_w + 1'b1;
		cnt_ext = {1'b0, cnt_inc};
		rem_dec = rem_w - 1'b1;

		if (!halted_w && ph != PH_ERROR) begin
			unique case (ph)
				PH_DELTA, PH_SYS_LEN, PH_META_LEN: begin
					if (b[7]) begin
						acc_n = {acc_add[24:0], 7'd0};
						cnt_n = cnt_inc;
						if (cnt_ext >= (CNT_W+1)'(MAX_NUMBER_BYTES)) begin
							phase_n        = PH_ERROR;
							res_valid      = 1'b1;
							res.kind       = KIND_ERROR;
							res.error_code = ERR_TOO_LONG;
						end
					end else if (ph == PH_DELTA) begin
						acc_n   = acc_add;
						tick_n  = tick_w + acc_add;
						phase_n = PH_STATUS;
					end else begin
						// length complete: header or end of track
						in_sysex_n = (ph == PH_SYS_LEN);
						rem_n      = acc_add;
						acc_n      = '0;
						cnt_n      = '0;
						phase_n    = (acc_add == '0) ? PH_DELTA : PH_PAYLOAD;
						if (ph == PH_META_LEN && meta_q == META_END_TRACK) begin
							if (acc_add == '0) begin
								halted_n   = 1'b1;
								res_valid  = 1'b1;
								res.kind   = KIND_END;
								res.number = META_END_TRACK;
							end
						end else begin
							res_valid          = 1'b1;
							res.kind           = (ph == PH_SYS_LEN) ? KIND_SYSEX_HDR :
							                     KIND_META_HDR;
							res.number         = (ph == PH_SYS_LEN) ? 8'd0 : meta_q;
							res.payload_length = acc_add;
							res.last           = (acc_add == '0);
						end
					end
				end
				PH_STATUS, PH_DATA_A: begin
					if (ph == PH_STATUS && b >= BYTE_SKIP_LO && b <= BYTE_SKIP_HI &&
						b != BYTE_SYSEX_END) begin
						// system bytes skipped where a status is expected
					end else if (ph == PH_STATUS &&
						(b == BYTE_SYSEX || b == BYTE_SYSEX_END)) begin
						rs_none_n = 1'b1;
						acc_n     = '0;
						cnt_n     = '0;
						phase_n   = PH_SYS_LEN;
					end else if (ph == PH_STATUS && b == BYTE_META) begin
						rs_none_n = 1'b1;
						phase_n   = PH_META_TYPE;
					end else if (ph == PH_STATUS && b[7]) begin
						rs_none_n = 1'b0;
						rs_n      = b;
						ss_none_n = 1'b0;
						ss_n      = b;
						phase_n   = PH_DATA_A;
					end else if (ph == PH_STATUS && rs_none && ss_none) begin
						phase_n        = PH_ERROR;
						res_valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_NO_STATUS;
					end else begin
						// first data byte with the status in force
						if (ph == PH_STATUS && rs_none) begin
							rs_none_n = 1'b0;
							rs_n      = ss;
						end
						first_n = b;
						if (rs_n[7:4] == HI_SYSTEM) begin
							phase_n        = PH_ERROR;
							res_valid      = 1'b1;
							res.kind       = KIND_ERROR;
							res.error_code = ERR_BAD_STAT;
						end else if (rs_n[7:4] == HI_PROGRAM || rs_n[7:4] == HI_PRESSURE) begin
							if (b[7]) begin
								phase_n        = PH_ERROR;
								res_valid      = 1'b1;
								res.kind       = KIND_ERROR;
								res.error_code = ERR_STRAY_B7;
							end else begin
								phase_n     = PH_DELTA;
								acc_n       = '0;
								cnt_n       = '0;
								res_valid   = 1'b1;
								res.kind    = (rs_n[7:4] == HI_PROGRAM) ? KIND_PROGRAM :
								              KIND_PRESSURE;
								res.channel = rs_n[3:0];
								res.amount  = {7'd0, b[6:0]};
							end
						end else begin
							phase_n = PH_DATA_B;
						end
					end
				end
				PH_DATA_B: begin
					phase_n = PH_DELTA;
					acc_n   = '0;
					cnt_n   = '0;
					if (b[7]) begin
						// stray status byte becomes the new status
						rs_none_n = 1'b0;
						rs_n      = b;
						ss_none_n = 1'b0;
						ss_n      = b;
					end
					if (!b[7] && a[7]) begin
						phase_n        = PH_ERROR;
						res_valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_STRAY_B7;
					end else if (rs[7:4] == HI_POLY_AT) begin
						// poly aftertouch consumed without an event
					end else if (rs[7:4] == HI_BEND) begin
						res_valid   = 1'b1;
						res.kind    = KIND_BEND;
						res.channel = rs[3:0];
						res.amount  = {(b[7] ? 7'd0 : b[6:0]), 7'd0} + {6'd0, a} -
						              BEND_CENTER;
					end else begin
						res_valid   = 1'b1;
						res.kind    = (rs[7:4] == HI_NOTE_OFF) ? KIND_NOTE_OFF :
						              (rs[7:4] == HI_NOTE_ON) ? KIND_NOTE_ON : KIND_CTRL;
						res.channel = rs[3:0];
						res.number  = {1'b0, a[6:0]};
						res.amount  = {7'd0, b[6:0]};
					end
				end
				PH_META_TYPE: begin
					meta_n  = b;
					acc_n   = '0;
					cnt_n   = '0;
					phase_n = PH_META_LEN;
				end
				PH_PAYLOAD: begin
					rem_n = rem_dec;
					if (rem_dec == '0) begin
						phase_n = PH_DELTA;
						acc_n   = '0;
						cnt_n   = '0;
					end
					if (!in_sysex_q && meta_q == META_END_TRACK) begin
						if (rem_dec == '0) begin
							halted_n   = 1'b1;
							res_valid  = 1'b1;
							res.kind   = KIND_END;
							res.number = META_END_TRACK;
						end
					end else begin
						res_valid         = 1'b1;
						res.kind          = KIND_PAYLOAD;
						res.data_byte     = b;
						res.last          = (rem_dec == '0);
						res.is_terminator = (rem_dec == '0) && in_sysex_q &&
						                    (b == BYTE_SYSEX_END);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_DELTA;
			rs_none_q  <= 1'b1;
			ss_none_q  <= 1'b1;
			rs_q       <= '0;
			ss_q       <= '0;
			tick_q     <= '0;
			acc_q      <= '0;
			cnt_q      <= '0;
			rem_q      <= '0;
			first_q    <= '0;
			meta_q     <= '0;
			in_sysex_q <= 1'b0;
			halted_q   <= 1'b0;
		end else if (accept) begin
			phase_q    <= phase_n;
			rs_none_q  <= rs_none_n;
			ss_none_q  <= ss_none_n;
			rs_q       <= rs_n;
			ss_q       <= ss_n;
			tick_q     <= tick_n;
			acc_q      <= acc_n;
			cnt_q      <= cnt_n;
			rem_q      <= rem_n;
			first_q    <= first_n;
			meta_q     <= meta_n;
			in_sysex_q <= in_sysex_n;
			halted_q   <= halted_n;
		end
	end

	// output and skid valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept && res_valid;
			end
		end else if (accept && res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	// output and skid payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else begin
				out_q <= res;
			end
		end else if (accept && res_valid) begin
			skid_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_q.data_byte, out_q.payload_length, out_q.amount,
	                        out_q.number, out_q.tick, out_q.channel, out_q.error_code};
	assign m_axis_tuser  = {out_q.is_terminator, out_q.kind};
	assign m_axis_tlast  = out_q.last;

`ifndef SYNTH
	// skid entry only fills behind a held output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid without output entry");

	// no events after an error until a new track
	a_error_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !s_axis_tuser && phase_q == PH_ERROR) |-> !res_valid)
		else $error("event produced in error phase");

	// no events after end of track until a new track
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !s_axis_tuser && halted_q) |-> !res_valid)
		else $error("event produced after end of track");

	// byte count of a number never passes the limit
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_NUMBER_BYTES))
		else $error("number byte count out of range");

	// a new event that arrives while the output is held lands in the skid entry
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(!skid_valid_q && accept && res_valid && out_valid_q && !m_axis_tready)
		|=> skid_valid_q)
		else $error("stalled event not captured");
`endif

endmodule

[tb/tb_midi_track_event_parser_unit.sv]
// ----------------------------------------------------------------------------
// tb_midi_track_event_parser_unit: self-checking bench for the track parser
// Streams MIDI tracks into the parser: mostly well-formed tracks with random
// content, plus broken tracks and raw noise. A scoreboard decodes every taken
// byte on its own and compares each event with the oldest one it predicted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_midi_track_event_parser_unit;
	import mtep_pkg::*;

	localparam logic [8:0] NO_STATUS   = 9'h100;
	localparam int         RANDOM_BYTES = 1750;
	localparam int         HOLD_CYCLES  = 80;
	localparam int         TAIL_CYCLES  = 20;
	localparam int         CYCLE_LIMIT  = 200000;

	// predicted event list and field compare
	class midi_event_scoreboard;
		phase_t      ph;
		logic [8:0]  run_st;
		logic [8:0]  saved_st;
		logic [31:0] tick_now;
		logic [31:0] vlq_val;
		logic [4:0]  vlq_len;
		logic [7:0]  data_a;
		logic [31:0] left_count;
		logic [7:0]  meta_code;
		bit          in_sx;
		bit          stopped;
		result_t     pending_events[$];
		int          mismatches;
		int          checked;
		int          kinds_seen[11];

		function new();
			clear_track();
		endfunction

		function void clear_track();
			ph = PH_DELTA;
			run_st = NO_STATUS;
			saved_st = NO_STATUS;
			tick_now = '0;
			vlq_val = '0;
			vlq_len = '0;
			data_a = '0;
			left_count = '0;
			meta_code = '0;
			in_sx = 1'b0;
			stopped = 1'b0;
		endfunction

		function void restart_vlq();
			vlq_val = '0;
			vlq_len = '0;
		endfunction

		// 1 done, 0 more bytes follow, -1 too many bytes
		function int take_vlq(logic [7:0] b);
			vlq_val = vlq_val + {25'd0, b[6:0]};
			if (!b[7])
				return 1;
			vlq_val = vlq_val << 7;
			vlq_len = vlq_len + 5'd1;
			if (vlq_len >= MAX_NUMBER_BYTES)
				return -1;
			return 0;
		endfunction

		function result_t make_event(kind_t k, logic [3:0] ch, logic [7:0] num,
				logic [13:0] amt, logic [31:0] len, logic [7:0] d, bit term, bit lst);
			result_t r;
			r = '0;
			r.kind = k;
			r.channel = ch;
			r.tick = tick_now;
			r.number = num;
			r.amount = amt;
			r.payload_length = len;
			r.data_byte = d;
			r.is_terminator = term;
			r.last = lst;
			return r;
		endfunction

		function result_t make_error(err_t code);
			result_t r;
			r = make_event(KIND_ERROR, 4'd0, 8'd0, 14'd0, 32'd0, 8'd0, 1'b0, 1'b0);
			r.error_code = code;
			ph = PH_ERROR;
			return r;
		endfunction

		// first data byte known: one-byte messages finish here
		function bit after_first(output result_t r);
			logic [3:0] hi;
			logic [3:0] ch;
			kind_t      k;
			hi = run_st[7:4];
			ch = run_st[3:0];
			if (run_st >= 9'h0f0) begin
				r = make_error(ERR_BAD_STAT);
				return 1'b1;
			end
			if (hi == HI_PROGRAM || hi == HI_PRESSURE) begin
				if (data_a[7]) begin
					r = make_error(ERR_STRAY_B7);
					return 1'b1;
				end
				ph = PH_DELTA;
				restart_vlq();
				if (hi == HI_PROGRAM)
					k = KIND_PROGRAM;
				else
					k = KIND_PRESSURE;
				r = make_event(k, ch, 8'd0, {7'd0, data_a[6:0]}, 32'd0, 8'd0, 1'b0, 1'b0);
				return 1'b1;
			end
			ph = PH_DATA_B;
			return 1'b0;
		endfunction

		// second data byte; a bit-7 byte here becomes the new status
		function bit second_byte(logic [7:0] b, output result_t r);
			logic [3:0] hi;
			logic [3:0] ch;
			logic [7:0] a;
			int         bend;
			kind_t      k;
			hi = run_st[7:4];
			ch = run_st[3:0];
			a = data_a;
			ph = PH_DELTA;
			restart_vlq();
			if (b[7]) begin
				run_st = {1'b0, b};
				saved_st = {1'b0, b};
			end else if (a[7]) begin
				r = make_error(ERR_STRAY_B7);
				return 1'b1;
			end
			if (hi == HI_POLY_AT)
				return 1'b0;
			if (hi == HI_BEND) begin
				bend = ((b[7] ? 0 : int'(b)) << 7) + int'(a) - 8192;
				r = make_event(KIND_BEND, ch, 8'd0, bend[13:0], 32'd0, 8'd0, 1'b0, 1'b0);
				return 1'b1;
			end
			if (hi == HI_NOTE_OFF)
				k = KIND_NOTE_OFF;
			else if (hi == HI_NOTE_ON)
				k = KIND_NOTE_ON;
			else
				k = KIND_CTRL;
			r = make_event(k, ch, {1'b0, a[6:0]}, {7'd0, b[6:0]}, 32'd0, 8'd0, 1'b0, 1'b0);
			return 1'b1;
		endfunction

		// one track byte in, at most one event out
		function bit decode_byte(input logic [7:0] b, input logic st, output result_t r);
			int          n;
			logic [31:0] len;
			if (st)
				clear_track();
			if (stopped || ph == PH_ERROR)
				return 1'b0;
			case (ph)
				PH_DELTA: begin
					n = take_vlq(b);
					if (n < 0) begin
						r = make_error(ERR_TOO_LONG);
						return 1'b1;
					end
					if (n > 0) begin
						tick_now = tick_now + vlq_val;
						ph = PH_STATUS;
					end
					return 1'b0;
				end
				PH_STATUS: begin
					if (b >= BYTE_SKIP_LO && b <= BYTE_SKIP_HI && b != BYTE_SYSEX_END)
						return 1'b0;
					if (b == BYTE_SYSEX || b == BYTE_SYSEX_END) begin
						run_st = NO_STATUS;
						restart_vlq();
						ph = PH_SYS_LEN;
						return 1'b0;
					end
					if (b == BYTE_META) begin
						run_st = NO_STATUS;
						ph = PH_META_TYPE;
						return 1'b0;
					end
					if (b[7]) begin
						run_st = {1'b0, b};
						saved_st = {1'b0, b};
						ph = PH_DATA_A;
						return 1'b0;
					end
					// data where a status belongs: fall back to the saved status
					if (run_st == NO_STATUS) begin
						if (saved_st == NO_STATUS) begin
							r = make_error(ERR_NO_STATUS);
							return 1'b1;
						end
						run_st = saved_st;
					end
					data_a = b;
					return after_first(r);
				end
				PH_DATA_A: begin
					data_a = b;
					return after_first(r);
				end
				PH_DATA_B:
					return second_byte(b, r);
				PH_META_TYPE: begin
					meta_code = b;
					restart_vlq();
					ph = PH_META_LEN;
					return 1'b0;
				end
				PH_SYS_LEN, PH_META_LEN: begin
					n = take_vlq(b);
					if (n < 0) begin
						r = make_error(ERR_TOO_LONG);
						return 1'b1;
					end
					if (n == 0)
						return 1'b0;
					len = vlq_val;
					in_sx = (ph == PH_SYS_LEN);
					left_count = len;
					restart_vlq();
					ph = (len == 0) ? PH_DELTA : PH_PAYLOAD;
					// end of track: payload swallowed, event after the last byte
					if (!in_sx && meta_code == META_END_TRACK) begin
						if (len != 0)
							return 1'b0;
						stopped = 1'b1;
						r = make_event(KIND_END, 4'd0, META_END_TRACK, 14'd0, 32'd0, 8'd0,
							1'b0, 1'b0);
						return 1'b1;
					end
					if (in_sx)
						r = make_event(KIND_SYSEX_HDR, 4'd0, 8'd0, 14'd0, len, 8'd0, 1'b0,
							len == 0);
					else
						r = make_event(KIND_META_HDR, 4'd0, meta_code, 14'd0, len, 8'd0, 1'b0,
							len == 0);
					return 1'b1;
				end
				PH_PAYLOAD: begin
					left_count = left_count - 32'd1;
					if (left_count == 0) begin
						ph = PH_DELTA;
						restart_vlq();
					end
					if (!in_sx && meta_code == META_END_TRACK) begin
						if (left_count != 0)
							return 1'b0;
						stopped = 1'b1;
						r = make_event(KIND_END, 4'd0, META_END_TRACK, 14'd0, vlq_val, 8'd0,
							1'b0, 1'b0);
						return 1'b1;
					end
					r = make_event(KIND_PAYLOAD, 4'd0, 8'd0, 14'd0, 32'd0, b,
						left_count == 0 && in_sx && b == BYTE_SYSEX_END, left_count == 0);
					return 1'b1;
				end
				default:
					return 1'b0;
			endcase
		endfunction

		function void note_byte(logic [7:0] b, logic st);
			result_t r;
			if (decode_byte(b, st, r))
				pending_events.insert(pending_events.size(), r);
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= 40)
				$display("%0t mismatch: %s", $time, msg);
		endtask

		task check_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want)
				report($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
		endtask

		task check_event(result_t got);
			result_t want;
			if (pending_events.size() == 0) begin
				report($sformatf("event kind %0d tick %0d with none predicted",
					got.kind, got.tick));
				return;
			end
			want = pending_events.pop_front();
			checked++;
			if (got.kind === want.kind)
				kinds_seen[int'(want.kind)]++;
			check_field("kind", want.kind, got.kind);
			check_field("error_code", want.error_code, got.error_code);
			check_field("channel", want.channel, got.channel);
			check_field("tick", want.tick, got.tick);
			check_field("number", want.number, got.number);
			check_field("amount", want.amount, got.amount);
			check_field("payload_length", want.payload_length, got.payload_length);
			check_field("data_byte", want.data_byte, got.data_byte);
			check_field("is_terminator", want.is_terminator, got.is_terminator);
			check_field("last", want.last, got.last);
		endtask
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata;   // [7:0] byte_in
	logic         s_axis_tuser;   // [0] start_track
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// [1:0] error_code, [5:2] channel, [37:6] tick, [45:38] number,
	// [59:46] amount, [91:60] payload_length, [99:92] data_byte, [103:100] zero
	logic [103:0] m_axis_tdata;
	logic [4:0]   m_axis_tuser;   // [3:0] kind, [4] is_terminator
	logic         m_axis_tlast;

	midi_event_scoreboard events_sb = new();

	int         send_idle_pct;
	int         recv_idle_pct;
	int         bytes_sent;
	int         tracks_sent;
	int         cycles;
	bit         track_head;
	bit         hold_request;
	bit         have_status;
	logic [3:0] running_hi;

	midi_track_event_parser_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// watch both sides: taken bytes feed the scoreboard, events get checked
	always @(posedge clk) begin
		result_t got;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				events_sb.note_byte(s_axis_tdata, s_axis_tuser);
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind = kind_t'(m_axis_tuser[3:0]);
				got.error_code = err_t'(m_axis_tdata[1:0]);
				got.channel = m_axis_tdata[5:2];
				got.tick = m_axis_tdata[37:6];
				got.number = m_axis_tdata[45:38];
				got.amount = m_axis_tdata[59:46];
				got.payload_length = m_axis_tdata[91:60];
				got.data_byte = m_axis_tdata[99:92];
				got.is_terminator = m_axis_tuser[4];
				got.last = m_axis_tlast;
				events_sb.check_event(got);
			end
		end
	end

	// receiver: random ready, or one long hold-off on request
	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// one byte transaction, with random idle cycles in front
	task send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= track_head;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		track_head = 1'b0;
		bytes_sent++;
	endtask

	// variable-length number over nbytes bytes, high group first
	task send_vlq(input logic [31:0] value, input int nbytes);
		logic [31:0] grp;
		for (int i = nbytes - 1; i >= 0; i--) begin
			grp = value >> (7 * i);
			send_byte({i > 0, grp[6:0]});
		end
	endtask

	task send_delta();
		int pick;
		pick = $urandom_range(99);
		if (pick < 60)
			send_byte(8'($urandom_range(127)));
		else if (pick < 85)
			send_vlq($urandom_range(16383), 2);
		else if (pick < 94)
			send_vlq($urandom, 5);
		else if (pick < 99)
			send_vlq($urandom, $urandom_range(MAX_NUMBER_BYTES, 6));
		else
			// continuation bit still set on the last allowed byte
			repeat (MAX_NUMBER_BYTES) send_byte(8'h80 | 8'($urandom_range(127)));
	endtask

	task send_payload(input int len, input bit sysex_end);
		for (int i = 0; i < len; i++) begin
			if (sysex_end && i == len - 1)
				send_byte(BYTE_SYSEX_END);
			else
				send_byte(8'($urandom_range(255)));
		end
	endtask

	// one event: delta, an optional system byte to skip, then a channel message, sysex or meta
	task send_event();
		int         pick;
		int         len;
		logic [7:0] b;
		logic [7:0] a;
		logic [7:0] mt;
		send_delta();
		if ($urandom_range(99) < 6) begin
			b = BYTE_SYSEX_END;
			while (b == BYTE_SYSEX_END)
				b = 8'($urandom_range(BYTE_SKIP_HI, BYTE_SKIP_LO));
			send_byte(b);
		end
		pick = $urandom_range(99);
		if (pick < 70) begin
			if (!have_status || $urandom_range(1)) begin
				running_hi = 4'($urandom_range(HI_BEND, HI_NOTE_OFF));
				send_byte({running_hi, 4'($urandom_range(15))});
				have_status = 1'b1;
			end
			a = 8'($urandom_range(127));
			b = 8'($urandom_range(127));
			pick = $urandom_range(99);
			if (pick < 3)
				a[7] = 1'b1;
			else if (pick < 7)
				b = 8'($urandom_range(255, 128));
			send_byte(a);
			if (running_hi != HI_PROGRAM && running_hi != HI_PRESSURE) begin
				send_byte(b);
				if (b[7])
					running_hi = b[7:4];
			end
		end else if (pick < 84) begin
			send_byte($urandom_range(1) ? BYTE_SYSEX : BYTE_SYSEX_END);
			if ($urandom_range(99) < 5) begin
				len = $urandom_range(200, 128);
				send_vlq(len, 2);
			end else begin
				len = $urandom_range(6);
				send_byte(8'(len));
			end
			send_payload(len, $urandom_range(99) < 60);
		end else begin
			mt = 8'($urandom_range(255));
			if (mt == META_END_TRACK)
				mt = 8'h7f;
			send_byte(BYTE_META);
			send_byte(mt);
			len = $urandom_range(5);
			send_byte(8'(len));
			send_payload(len, 1'b0);
		end
	endtask

	// one track: noise, or events that are mostly closed by an end-of-track meta
	task send_track();
		int pick;
		int len;
		track_head = 1'b1;
		have_status = 1'b0;
		tracks_sent++;
		pick = $urandom_range(99);
		if (pick < 8) begin
			repeat ($urandom_range(20, 4)) send_byte(8'($urandom_range(255)));
			return;
		end
		if (pick < 12) begin
			// data with no status ever seen
			send_delta();
			send_byte(8'($urandom_range(127)));
		end
		repeat ($urandom_range(30, 3)) send_event();
		pick = $urandom_range(99);
		if (pick < 85) begin
			send_delta();
			send_byte(BYTE_META);
			send_byte(META_END_TRACK);
			if (pick < 70) begin
				send_byte(8'h00);
			end else begin
				len = $urandom_range(3, 1);
				send_byte(8'(len));
				send_payload(len, 1'b0);
			end
			// bytes after the end are ignored
			repeat ($urandom_range(3)) send_byte(8'($urandom_range(255)));
		end
	endtask

	// short directed track: extremes, bend limits, running status, empty sysex
	task send_directed();
		logic [7:0] seq[$];
		seq = '{8'h00, 8'h9f, 8'h7f, 8'h7f,
			8'h81, 8'h00, 8'h80, 8'h00, 8'h00,
			8'h00, 8'he3, 8'h00, 8'h00,
			8'h00, 8'h7f, 8'h7f,
			8'h00, 8'hc5, 8'h7f,
			8'h00, 8'hf4, 8'hf0, 8'h00,
			8'h00, 8'hff, 8'h2f, 8'h00};
		track_head = 1'b1;
		tracks_sent++;
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	task wait_for_events();
		s_axis_tvalid <= 1'b0;
		while (events_sb.pending_events.size() != 0)
			@(posedge clk);
	endtask

	// main sequence
	initial begin
		int  kinds_hit;
		bit  hold_done;
		bit  pause_done;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= 8'h00;
		s_axis_tuser <= 1'b0;
		hold_request = 1'b0;
		hold_done = 1'b0;
		pause_done = 1'b0;
		send_idle_pct = 11;
		recv_idle_pct = 62;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_directed();
		bytes_sent = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			if (bytes_sent >= 2 * RANDOM_BYTES / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (bytes_sent >= RANDOM_BYTES / 3) begin
				send_idle_pct = 62;
				recv_idle_pct = 11;
			end
			if (!hold_done && bytes_sent >= 250) begin
				hold_request = 1'b1;
				hold_done = 1'b1;
			end
			if (!pause_done && bytes_sent >= 800) begin
				wait_for_events();
				repeat (3) @(posedge clk);
				pause_done = 1'b1;
			end
			send_track();
		end
		wait_for_events();
		repeat (TAIL_CYCLES) @(posedge clk);
		kinds_hit = 0;
		foreach (events_sb.kinds_seen[k])
			if (events_sb.kinds_seen[k] != 0)
				kinds_hit++;
		$display("streamed %0d random track bytes over %0d tracks, %0d events compared",
			bytes_sent, tracks_sent, events_sb.checked);
		$display("event kinds reached: %0d of 11, mismatches: %0d",
			kinds_hit, events_sb.mismatches);
		if (events_sb.mismatches == 0 && events_sb.pending_events.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[files.f]
design/mtep_pkg.sv
design/midi_track_event_parser_unit.sv
tb/tb_midi_track_event_parser_unit.sv
